/* rtl/core/kdr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_pkg
// Shared flow type, constants and crc helper function for the sector key derive core.
// ----------------------------------------------------------------------------
package kdr_pkg;

  localparam int NIBBLES = 10;
  localparam int CELLS = 6;
  localparam int KEY_W = 48;
  localparam int CRC_W = 64;
  localparam int STREAM_W = 8 * CELLS;

  localparam logic [CRC_W-1:0] KEY_POLY  = 64'h42F0_E1EB_A9EA_3693;
  localparam logic [KEY_W-1:0] FIXED_KEY = 48'hCB7C_1020_0B4B;
  localparam logic [7:0]       HEAD_BYTE = 8'hC2;

  localparam logic [3:0] PERM_TAB [NIBBLES][16] = '{
    '{4'h4, 4'h5, 4'h7, 4'h6, 4'h3, 4'h2, 4'h0, 4'h1,
      4'hB, 4'hA, 4'h8, 4'h9, 4'hC, 4'hD, 4'hF, 4'hE},
    '{4'h4, 4'hB, 4'hB, 4'h4, 4'hB, 4'h4, 4'h4, 4'hB,
      4'hA, 4'h5, 4'h5, 4'hA, 4'h5, 4'hA, 4'hA, 4'h5},
    '{4'hB, 4'h6, 4'h0, 4'hD, 4'hD, 4'h0, 4'h6, 4'hB,
      4'h6, 4'hB, 4'hD, 4'h0, 4'h0, 4'hD, 4'hB, 4'h6},
    '{4'hE, 4'h5, 4'h9, 4'h2, 4'h0, 4'hB, 4'h7, 4'hC,
      4'h3, 4'h8, 4'h4, 4'hF, 4'hD, 4'h6, 4'hA, 4'h1},
    '{4'h4, 4'hE, 4'h1, 4'hB, 4'hF, 4'h5, 4'hA, 4'h0,
      4'h3, 4'h9, 4'h6, 4'hC, 4'h8, 4'h2, 4'hD, 4'h7},
    '{4'hA, 4'h4, 4'h7, 4'h9, 4'h0, 4'hE, 4'hD, 4'h3,
      4'hE, 4'h0, 4'h3, 4'hD, 4'h4, 4'hA, 4'h9, 4'h7},
    '{4'hE, 4'h6, 4'hE, 4'h6, 4'hF, 4'h7, 4'hF, 4'h7,
      4'hD, 4'h5, 4'hD, 4'h5, 4'hC, 4'h4, 4'hC, 4'h4},
    '{4'h7, 4'h1, 4'hB, 4'hD, 4'hE, 4'h8, 4'h2, 4'h4,
      4'h4, 4'h2, 4'h8, 4'hE, 4'hD, 4'hB, 4'h1, 4'h7},
    '{4'hD, 4'hB, 4'h0, 4'h6, 4'h6, 4'h0, 4'hB, 4'hD,
      4'hA, 4'hC, 4'h7, 4'h1, 4'h1, 4'h7, 4'hC, 4'hA},
    '{4'hE, 4'h1, 4'h1, 4'hE, 4'h1, 4'hE, 4'hE, 4'h1,
      4'h1, 4'hE, 4'hE, 4'h1, 4'hE, 4'h1, 4'h1, 4'hE}
  };

  typedef struct packed {
    logic                valid;
    logic                fixed;
    logic [CRC_W-1:0]    crc;
    logic [STREAM_W-1:0] bytes;
  } kdr_flow_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-8){1'b0}}};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ KEY_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/rfid_sector_key_derive_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfid_sector_key_derive_core
// Sector key derivation: nibble table mix followed by a chain of crc cells.
// ----------------------------------------------------------------------------
// pipeline: one nibble stage followed by six crc cells, each registered
// throughput: one beat per cycle; the whole chain holds while out_ready is low
// and the last cell has a result waiting
// reset: rst_n clears all stage valid flags, no result is pending afterwards
// ----------------------------------------------------------------------------
module rfid_sector_key_derive_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_card_uid,
  input  logic [7:0]                in_sector_number,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kdr_pkg::KEY_W-1:0] out_sector_key
);

  kdr_pkg::kdr_flow_t link [kdr_pkg::CELLS+1];
  logic adv;

  assign adv = !link[kdr_pkg::CELLS].valid || out_ready;

  kdr_nib_stage u_nib (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_valid      (in_valid),
    .card_uid      (in_card_uid),
    .sector_number (in_sector_number),
    .q             (link[0])
  );

  for (genvar i = 0; i < kdr_pkg::CELLS; i++) begin : g_cell
    kdr_crc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d     (link[i]),
      .q     (link[i+1])
    );
  end

  assign in_ready       = adv;
  assign out_valid      = link[kdr_pkg::CELLS].valid;
  assign out_sector_key = link[kdr_pkg::CELLS].fixed ? kdr_pkg::FIXED_KEY
                          : link[kdr_pkg::CELLS].crc[kdr_pkg::KEY_W-1:0];

endmodule

/* rtl/core/kdr_nib_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_nib_stage
// Front stage: splits the request into nibbles, runs the table mix and loads
// the byte stream for the crc cells.
// ----------------------------------------------------------------------------
module kdr_nib_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       card_uid,
  input  logic [7:0]        sector_number,
  output kdr_pkg::kdr_flow_t q
);

  kdr_pkg::kdr_flow_t q_r;
  kdr_pkg::kdr_flow_t q_nxt;
  logic [3:0] d [kdr_pkg::NIBBLES];
  logic [3:0] n [kdr_pkg::NIBBLES];

  always_comb begin
    logic [3:0] v;
    for (int k = 0; k < 8; k++) begin
      d[k] = card_uid[31-4*k -: 4];
    end
    d[8] = sector_number[7:4];
    d[9] = sector_number[3:0];
    for (int k = 0; k < kdr_pkg::NIBBLES; k++) begin
      v = kdr_pkg::PERM_TAB[k][d[0]];
      for (int j = 1; j <= k; j++) begin
        v = v ^ kdr_pkg::PERM_TAB[k-j][0] ^ kdr_pkg::PERM_TAB[k-j][d[j]];
      end
      n[k] = v;
    end
    q_nxt.valid = in_valid;
    q_nxt.fixed = (sector_number == 8'h00);
    q_nxt.crc   = '0;
    q_nxt.bytes[kdr_pkg::STREAM_W-1 -: 8] = kdr_pkg::HEAD_BYTE;
    for (int k = 0; k < kdr_pkg::NIBBLES; k++) begin
      q_nxt.bytes[4*kdr_pkg::NIBBLES-1-4*k -: 4] = n[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      q_r.fixed <= q_nxt.fixed;
      q_r.crc   <= q_nxt.crc;
      q_r.bytes <= q_nxt.bytes;
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/kdr_crc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdr_crc_cell
// One link of the crc chain: folds the leading stream byte into the running
// crc and hands the shifted stream to the next cell.
// ----------------------------------------------------------------------------
module kdr_crc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  kdr_pkg::kdr_flow_t d,
  output kdr_pkg::kdr_flow_t q
);

  kdr_pkg::kdr_flow_t q_r;
  kdr_pkg::kdr_flow_t q_nxt;

  always_comb begin
    q_nxt.valid = d.valid;
    q_nxt.fixed = d.fixed;
    q_nxt.crc   = kdr_pkg::crc_byte(d.crc, d.bytes[kdr_pkg::STREAM_W-1 -: 8]);
    q_nxt.bytes = {d.bytes[kdr_pkg::STREAM_W-9:0], 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      q_r.fixed <= q_nxt.fixed;
      q_r.crc   <= q_nxt.crc;
      q_r.bytes <= q_nxt.bytes;
    end
  end

  assign q = q_r;

endmodule
